FILE: src/blg_pkg.sv
// ----------------------------------------------------------------------------
// Bresenham line generator package
// Shared widths, mode codes and the pixel record passed between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package blg_pkg;

    localparam int COORD_BITS  = 12;
    localparam int PITCH_BITS  = 14;
    localparam int ADDR_BITS   = 26;
    localparam int COLOR_BITS  = 32;

    localparam int S_TDATA_W   = 4 * COORD_BITS + COLOR_BITS;               // 80
    localparam int M_FIELDS_W  = 2 * COORD_BITS + ADDR_BITS + COLOR_BITS;   // 82
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;                // 88

    localparam logic [PITCH_BITS-1:0] PITCH_RESET = PITCH_BITS'(1024);

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    typedef struct packed {
        logic                  valid;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
    } pixel_t;

endpackage

`default_nettype wire

FILE: src/blg_tracer.sv
// ----------------------------------------------------------------------------
// Bresenham line tracer
// Holds the line state and makes one pixel word (or a zero no-line word) per accepted word into a stage reg.
// ----------------------------------------------------------------------------
`default_nettype none

module blg_tracer
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           in_mode,
    input  wire logic [blg_pkg::S_TDATA_W-1:0]  in_data,
    output logic                                pix_valid,
    input  wire logic                           pix_ready,
    output blg_pkg::pixel_t                     pix
);

    localparam int CB = blg_pkg::COORD_BITS;

    logic [CB-1:0]        cur_x_reg, cur_x_next;
    logic [CB-1:0]        cur_y_reg, cur_y_next;
    logic [CB-1:0]        goal_x_reg, goal_x_next;
    logic [CB-1:0]        goal_y_reg, goal_y_next;
    logic [CB:0]          dx_reg, dx_next;
    logic signed [CB+1:0] ndy_reg, ndy_next;
    logic signed [CB+2:0] err_reg, err_next;
    logic                 dxn_reg, dxn_next;
    logic                 dyn_reg, dyn_next;
    logic [blg_pkg::COLOR_BITS-1:0] color_reg, color_next;
    logic                 active_reg, active_next;

    logic                 vld_reg, vld_next;
    blg_pkg::pixel_t      pix_reg, pix_next;

    logic                 acc;
    logic [CB-1:0]        xs, ys, xe, ye;
    logic [CB-1:0]        dy_abs;
    logic signed [CB+3:0] e2, ndy16, dx16, err_sum;
    logic                 step_x, step_y;

    assign in_ready  = !vld_reg || pix_ready;
    assign acc       = in_valid && in_ready;
    assign pix_valid = vld_reg;
    assign pix       = pix_reg;

    assign xs = in_data[CB-1:0];
    assign ys = in_data[2*CB-1:CB];
    assign xe = in_data[3*CB-1:2*CB];
    assign ye = in_data[4*CB-1:3*CB];

    assign e2     = {err_reg, 1'b0};
    assign ndy16  = {{2{ndy_reg[CB+1]}}, ndy_reg};
    assign dx16   = {3'b000, dx_reg};
    assign step_x = (e2 >= ndy16) && (cur_x_reg != goal_x_reg);
    assign step_y = (e2 <= dx16) && (cur_y_reg != goal_y_reg);
    assign err_sum = {err_reg[CB+2], err_reg}
                   + (step_x ? ndy16 : '0)
                   + (step_y ? dx16 : '0);
    assign dy_abs = (ye < ys) ? (ys - ye) : (ye - ys);

    always_comb
    begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        goal_x_next = goal_x_reg;
        goal_y_next = goal_y_reg;
        dx_next     = dx_reg;
        ndy_next    = ndy_reg;
        err_next    = err_reg;
        dxn_next    = dxn_reg;
        dyn_next    = dyn_reg;
        color_next  = color_reg;
        active_next = active_reg;
        vld_next    = vld_reg && !pix_ready;
        pix_next    = pix_reg;

        if (acc)
        begin
            vld_next = 1'b1;
            case (in_mode)
                blg_pkg::MODE_START:
                begin
                    cur_x_next  = xs;
                    cur_y_next  = ys;
                    goal_x_next = xe;
                    goal_y_next = ye;
                    dxn_next    = xe < xs;
                    dyn_next    = ye < ys;
                    dx_next     = (xe < xs) ? {1'b0, xs - xe} : {1'b0, xe - xs};
                    ndy_next    = (CB+2)'(0) - $signed({2'b00, dy_abs});
                    err_next    = $signed({2'b00, dx_next}) + {ndy_next[CB+1], ndy_next};
                    color_next  = in_data[blg_pkg::S_TDATA_W-1:4*CB];
                    active_next = !((xs == xe) && (ys == ye));
                    pix_next.valid = 1'b1;
                    pix_next.x     = xs;
                    pix_next.y     = ys;
                    pix_next.color = color_next;
                    pix_next.last  = !active_next;
                end
                blg_pkg::MODE_STEP:
                begin
                    if (active_reg)
                    begin
                        if (step_x)
                            cur_x_next = dxn_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                        if (step_y)
                            cur_y_next = dyn_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
                        err_next    = err_sum[CB+2:0];
                        active_next = !((cur_x_next == goal_x_reg) &&
                                        (cur_y_next == goal_y_reg));
                        pix_next.valid = 1'b1;
                        pix_next.x     = cur_x_next;
                        pix_next.y     = cur_y_next;
                        pix_next.color = color_reg;
                        pix_next.last  = !active_next;
                    end
                    else
                    begin
                        pix_next = '0;
                    end
                end
                default:
                begin
                    pix_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            goal_x_reg <= '0;
            goal_y_reg <= '0;
            dx_reg     <= '0;
            ndy_reg    <= '0;
            err_reg    <= '0;
            dxn_reg    <= 1'b0;
            dyn_reg    <= 1'b0;
            color_reg  <= '0;
            active_reg <= 1'b0;
            vld_reg    <= 1'b0;
        end
        else
        begin
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            goal_x_reg <= goal_x_next;
            goal_y_reg <= goal_y_next;
            dx_reg     <= dx_next;
            ndy_reg    <= ndy_next;
            err_reg    <= err_next;
            dxn_reg    <= dxn_next;
            dyn_reg    <= dyn_next;
            color_reg  <= color_next;
            active_reg <= active_next;
            vld_reg    <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
    end

    // no-line word carries all-zero fields
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && !pix_reg.valid) |->
            (pix_reg.x == '0 && pix_reg.y == '0 && pix_reg.color == '0 && !pix_reg.last))
        else $error("idle pixel word not zero");

    // end pixel retires the line
    a_last_retires: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && pix_next.last) |=> !active_reg)
        else $error("line still active after last pixel");

    // stage holds while downstream stalls
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && !pix_ready) |=> (vld_reg && $stable(pix_reg)))
        else $error("pixel stage changed under stall");

    // a step moves the current x pixel by at most one (y is not checked here)
    a_unit_step: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && in_mode == blg_pkg::MODE_STEP) |=>
            ((cur_x_reg - $past(cur_x_reg)) == CB'(0) ||
             (cur_x_reg - $past(cur_x_reg)) == CB'(1) ||
             ($past(cur_x_reg) - cur_x_reg) == CB'(1)))
        else $error("x moved by more than one");

endmodule

`default_nettype wire

FILE: src/blg_addr.sv
// ----------------------------------------------------------------------------
// Bresenham line address stage
// Forms row * pitch + column and drives the registered output word.
// ----------------------------------------------------------------------------
`default_nettype none

module blg_addr
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [blg_pkg::PITCH_BITS-1:0]  pitch,
    input  wire logic                            pix_valid,
    output logic                                 pix_ready,
    input  wire blg_pkg::pixel_t                 pix,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [blg_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                 m_tuser,
    output logic                                 m_tlast
);

    localparam int AB  = blg_pkg::ADDR_BITS;
    localparam int CB  = blg_pkg::COORD_BITS;
    localparam int PB  = blg_pkg::PITCH_BITS;
    localparam int PAD = blg_pkg::M_TDATA_W - blg_pkg::M_FIELDS_W;

    logic                                 vld_reg, vld_next;
    logic [blg_pkg::M_TDATA_W-1:0]        data_reg, data_next;
    logic                                 user_reg, user_next;
    logic                                 last_reg, last_next;
    logic [AB-1:0]                        prod, addr;

    assign pix_ready = !vld_reg || m_tready;

    assign prod = {(AB-CB)'(0), pix.y} * {(AB-PB)'(0), pitch};
    assign addr = prod + {(AB-CB)'(0), pix.x};

    always_comb
    begin
        vld_next  = vld_reg && !m_tready;
        data_next = data_reg;
        user_next = user_reg;
        last_next = last_reg;
        if (pix_valid && pix_ready)
        begin
            vld_next  = 1'b1;
            data_next = {PAD'(0), pix.color, addr, pix.y, pix.x};
            user_next = pix.valid;
            last_next = pix.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    // no-line word has zero address
    a_idle_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && !user_reg) |-> (data_reg[2*CB+AB-1:2*CB] == '0))
        else $error("idle word with nonzero address");

endmodule

`default_nettype wire

FILE: src/bresenham_line_pixel_generator.sv
// ----------------------------------------------------------------------------
// Bresenham line pixel generator
// Start words load a line, step words walk it one pixel per word.
// ----------------------------------------------------------------------------
//  channel  dir  fields (low bit up)
//  s_*      in   tuser: mode; tdata: x_start, y_start, x_end, y_end, line_color
//  m_*      out  tuser: pixel_valid; tlast: last_pixel;
//                tdata: pixel_x, pixel_y, pixel_address, pixel_color, 6'b0 pad
//  cfg_*    in   cfg_data: pitch_words
//
//  One word in and one word out per clock while m_tready is high; the path is
//  registered in the tracer stage, then the address multiply-add goes into the output register.
//  rst_n clears the line state and the stage valids; pitch resets to 1024.
//  m_tready low stalls both stages; s_tready falls only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_line_pixel_generator
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [blg_pkg::S_TDATA_W-1:0]     s_tdata,  // x_start, y_start, x_end, y_end, line_color
    input  wire logic                              s_tuser,  // mode
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [blg_pkg::M_TDATA_W-1:0]          m_tdata,  // pixel_x, pixel_y, pixel_address, pixel_color
    output logic                                   m_tuser,  // pixel_valid
    output logic                                   m_tlast,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [blg_pkg::PITCH_BITS-1:0]    cfg_data
);

    logic [blg_pkg::PITCH_BITS-1:0] pitch_reg, pitch_next;
    logic                           pix_valid, pix_ready;
    blg_pkg::pixel_t                pix;

    assign cfg_ready  = 1'b1;
    assign pitch_next = (cfg_valid && cfg_ready) ? cfg_data : pitch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pitch_reg <= blg_pkg::PITCH_RESET;
        else
            pitch_reg <= pitch_next;
    end

    blg_tracer u_tracer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tuser),
        .in_data   (s_tdata),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

    blg_addr u_addr
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pitch     (pitch_reg),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
